>>> hdl/sdcr_pkg.sv
// shared types, constants and helpers of the disk command responder
package sdcr_pkg;

	localparam int DRIVES_DEF = 8;
	localparam int HEADER_BYTES_DEF = 16;

	localparam logic [7:0] DEV_FIRST = 8'h31;
	localparam logic [7:0] DEV_LAST = 8'h38;
	localparam logic [7:0] DEV_ZERO = 8'h30;
	localparam logic [7:0] ST_DOUBLE = 8'h30;
	localparam logic [7:0] ST_SINGLE = 8'h10;

	localparam logic [7:0] CMD_STATUS = 8'h53;
	localparam logic [7:0] CMD_READ = 8'h52;
	localparam logic [7:0] CMD_PUT = 8'h50;
	localparam logic [7:0] CMD_WRITE = 8'h57;
	localparam logic [7:0] CMD_SPEED = 8'h3F;
	localparam logic [7:0] CMD_FORMAT = 8'h21;
	localparam logic [7:0] CMD_GETCFG = 8'h4E;
	localparam logic [7:0] CMD_SETCFG = 8'h4F;

	localparam logic [1:0] REG_PRESENT = 2'd0;
	localparam logic [1:0] REG_FORMATS = 2'd1;
	localparam logic [1:0] REG_DENSITY = 2'd2;

	typedef enum logic [1:0] {
		FMT_HEADER = 2'd0,
		FMT_RAW = 2'd1,
		FMT_EXEC = 2'd2,
		FMT_MENU = 2'd3
	} fmt_t;

	typedef enum logic [3:0] {
		RK_FALLBACK = 4'd0,
		RK_NAK = 4'd1,
		RK_STATUS = 4'd2,
		RK_READ = 4'd3,
		RK_WBEGIN = 4'd4,
		RK_WDATA = 4'd5,
		RK_WOK = 4'd6,
		RK_WNAK = 4'd7,
		RK_WERR = 4'd8,
		RK_SPEED = 4'd9,
		RK_FORMAT = 4'd10,
		RK_GETCFG = 4'd11,
		RK_SETCFG = 4'd12
	} rkind_t;

	typedef struct packed {
		logic [3:0] resp_kind;
		logic [3:0] drive;
		logic [7:0] command;
		logic [15:0] sector;
		logic [23:0] image_offset;
		logic from_loader;
		logic [8:0] transfer_length;
		logic [7:0] status_byte;
		logic [7:0] data_byte;
	} resp_t;

	typedef struct packed {
		logic req_type;
		logic [7:0] rx_byte;
		logic cmd_line;
	} req_t;

	typedef struct packed {
		logic frame_end;
		logic frame_byte;
		logic data_byte;
		logic [7:0] b;
	} job_t;

	function automatic logic [7:0] sum_step(input logic [7:0] c, input logic [7:0] d);
		logic [8:0] t;
		t = {1'b0, c} + {1'b0, d};
		return t[7:0] + {7'd0, t[8]};
	endfunction

endpackage

>>> hdl/sdcr_if.sv
// valid/ready channel carrying one beat of payload
interface sdcr_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

>>> hdl/sio_disk_command_responder.sv
// top level of the serial disk command responder
// latency: a request's response is valid the cycle after the request is taken from the queue;
// between acceptance and response lie the two-entry request queue and the output register
// throughput: one request per cycle while the response output is not held by back-pressure (resp.ready low)
// reset: arst_n clears the config registers, queue and frame (frame bytes read 0xFF)
module sio_disk_command_responder import sdcr_pkg::*; #(
	parameter int DRIVES = DRIVES_DEF,
	parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
	input logic clk,
	input logic arst_n,
	sdcr_if.sink req,
	sdcr_if.source resp,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [15:0] cfg_data
);
	logic [7:0] present_q, density_q;
	logic [15:0] formats_q;
	job_t job;
	logic job_valid, job_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= 8'd0;
			formats_q <= 16'd0;
			density_q <= 8'd0;
		end else if (cfg_we) begin
			priority case (cfg_index)
				REG_PRESENT: present_q <= cfg_data[7:0];
				REG_FORMATS: formats_q <= cfg_data;
				REG_DENSITY: density_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	sdcr_front u_front (
		.clk(clk), .arst_n(arst_n), .req(req),
		.job(job), .job_valid(job_valid), .job_ready(job_ready)
	);

	sdcr_back #(.DRIVES(DRIVES), .HEADER_BYTES(HEADER_BYTES)) u_back (
		.clk(clk), .arst_n(arst_n),
		.job(job), .job_valid(job_valid), .job_ready(job_ready),
		.present_q(present_q), .formats_q(formats_q), .density_q(density_q),
		.resp(resp)
	);
endmodule

>>> hdl/sdcr_front.sv
// front end: accepts requests, classifies them and queues jobs
module sdcr_front import sdcr_pkg::*; (
	input logic clk,
	input logic arst_n,
	sdcr_if.sink req,
	output job_t job,
	output logic job_valid,
	input logic job_ready
);
	job_t q_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	job_t cls;
	logic push, pop;

	always_comb begin
		cls.frame_end = req.payload.req_type;
		cls.frame_byte = !req.payload.req_type && req.payload.cmd_line;
		cls.data_byte = !req.payload.req_type && !req.payload.cmd_line;
		cls.b = req.payload.rx_byte;
	end

	assign req.ready = cnt_q != 2'd2;
	assign push = req.valid && req.ready;
	assign job_valid = cnt_q != 2'd0;
	assign pop = job_valid && job_ready;
	assign job = q_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) q_q[wp_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

>>> hdl/sdcr_back.sv
// back end: frame collection, decode, write data phase, output register
module sdcr_back import sdcr_pkg::*; #(
	parameter int DRIVES = DRIVES_DEF,
	parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
	input logic clk,
	input logic arst_n,
	input job_t job,
	input logic job_valid,
	output logic job_ready,
	input logic [7:0] present_q,
	input logic [15:0] formats_q,
	input logic [7:0] density_q,
	sdcr_if.source resp
);
	localparam logic [23:0] HDR = 24'(HEADER_BYTES);

	logic [7:0] fb_q [5];
	logic [2:0] cnt_q;
	logic dph_q, wref_q;
	logic [8:0] rem_q, widx_q;
	logic [7:0] dsum_q;
	logic [2:0] wdrv_q;
	logic [23:0] wbase_q;
	logic ov_q;
	resp_t out_q;

	logic take, emit, start_w;
	resp_t r;
	logic [7:0] c, dev, cmd;
	logic [15:0] sec;
	logic [2:0] idx;
	logic [3:0] drv;
	fmt_t f;
	logic big;
	logic [8:0] len;
	logic [23:0] off, sm1, sm4;

	assign job_ready = !ov_q || resp.ready;
	assign take = job_valid && job_ready;

	always_comb begin
		c = sum_step(sum_step(sum_step(sum_step(8'd0, fb_q[0]), fb_q[1]), fb_q[2]), fb_q[3]);
		dev = fb_q[0];
		cmd = fb_q[1];
		sec = {fb_q[3], fb_q[2]};
		drv = 4'(dev - DEV_ZERO);
		idx = 3'(drv - 4'd1);
		f = fmt_t'(formats_q[{idx, 1'b0} +: 2]);
		big = density_q[idx];
		sm1 = 24'(sec) - 24'd1;
		sm4 = 24'(sec) - 24'd4;
		len = (sec < 16'd4 || !big) ? 9'd128 : 9'd256;
		if (f == FMT_RAW) off = big ? (sm1 << 8) : (sm1 << 7);
		else if (sec < 16'd4) off = HDR + (sm1 << 7);
		else off = HDR + 24'd384 + (big ? (sm4 << 8) : (sm4 << 7));
		r = '0;
		emit = 1'b0;
		start_w = 1'b0;
		if (job.frame_end) begin
			if (!dph_q) begin
				if (c != fb_q[4]) begin
					emit = 1'b1;
					r.resp_kind = RK_FALLBACK;
				end else if (dev >= DEV_FIRST && dev <= DEV_LAST
						&& 32'(drv) <= DRIVES && present_q[idx]) begin
					emit = 1'b1;
					r.drive = drv;
					r.command = cmd;
					unique case (cmd)
						CMD_STATUS: begin
							r.resp_kind = RK_STATUS;
							r.status_byte = big ? ST_DOUBLE : ST_SINGLE;
						end
						CMD_READ: begin
							r.sector = sec;
							if (sec == 16'd0) r.resp_kind = RK_NAK;
							else begin
								r.resp_kind = RK_READ;
								if (f == FMT_EXEC) begin
									r.transfer_length = 9'd128;
									r.from_loader = sec < 16'd4;
									r.image_offset = (sec < 16'd4) ? (sm1 << 7) : (sm4 << 7);
								end else begin
									r.transfer_length = len;
									r.image_offset = off;
								end
							end
						end
						CMD_PUT, CMD_WRITE: begin
							r.sector = sec;
							if (sec == 16'd0) r.resp_kind = RK_NAK;
							else begin
								r.resp_kind = RK_WBEGIN;
								r.transfer_length = len;
								r.image_offset = (f == FMT_EXEC) ? 24'd0 : off;
								start_w = 1'b1;
							end
						end
						CMD_SPEED: r.resp_kind = RK_SPEED;
						CMD_FORMAT: begin
							r.resp_kind = RK_FORMAT;
							r.transfer_length = 9'd128;
							r.image_offset = (f == FMT_HEADER) ? HDR : 24'd0;
						end
						CMD_GETCFG: r.resp_kind = RK_GETCFG;
						CMD_SETCFG: r.resp_kind = RK_SETCFG;
						default: r.resp_kind = RK_NAK;
					endcase
				end
			end
		end else if (job.data_byte && dph_q) begin
			r.drive = {1'b0, wdrv_q} + 4'd1;
			if (rem_q != 9'd0) begin
				emit = !wref_q;
				r.resp_kind = RK_WDATA;
				r.image_offset = wbase_q + 24'(widx_q);
				r.data_byte = job.b;
			end else begin
				emit = 1'b1;
				if (job.b != dsum_q) r.resp_kind = RK_WNAK;
				else if (wref_q) r.resp_kind = RK_WERR;
				else r.resp_kind = RK_WOK;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && emit) out_q <= r;
		if (take && start_w) begin
			wdrv_q <= idx;
			wbase_q <= r.image_offset;
			wref_q <= f == FMT_EXEC;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 5; i++) fb_q[i] <= 8'hFF;
			cnt_q <= 3'd0;
			dph_q <= 1'b0;
			rem_q <= 9'd0;
			widx_q <= 9'd0;
			dsum_q <= 8'd0;
			ov_q <= 1'b0;
		end else begin
			if (resp.ready) ov_q <= 1'b0;
			if (take) begin
				if (emit) ov_q <= 1'b1;
				if (job.frame_end && !dph_q) begin
					for (int i = 0; i < 5; i++) fb_q[i] <= 8'hFF;
					cnt_q <= 3'd0;
					if (start_w) begin
						dph_q <= 1'b1;
						rem_q <= len;
						dsum_q <= 8'd0;
						widx_q <= 9'd0;
					end
				end else if (job.frame_byte) begin
					dph_q <= 1'b0;
					if (cnt_q < 3'd5) begin
						fb_q[cnt_q] <= job.b;
						cnt_q <= cnt_q + 3'd1;
					end
				end else if (job.data_byte && dph_q) begin
					if (rem_q != 9'd0) begin
						dsum_q <= sum_step(dsum_q, job.b);
						rem_q <= rem_q - 9'd1;
						widx_q <= widx_q + 9'd1;
					end else dph_q <= 1'b0;
				end
			end
		end
	end

	assign resp.valid = ov_q;
	assign resp.payload = out_q;
endmodule
